[design/kps_pkg.sv]
// Shared types and constants for the Kalman predict step block.
package kps_pkg;

	localparam int REQ_W = 3;
	localparam int VAL_W = 32;
	localparam int ACC_W = 64;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_A  = 3'd0,
		REQ_LOAD_X0 = 3'd1,
		REQ_LOAD_Y0 = 3'd2,
		REQ_LOAD_X  = 3'd3,
		REQ_LOAD_P  = 3'd4,
		REQ_LOAD_Q  = 3'd5,
		REQ_COMPUTE = 3'd6,
		REQ_NONE    = 3'd7
	} req_t;

	// One queued request handed from the front end to the compute engine.
	typedef struct packed {
		req_t              req;
		logic [1:0]        row;
		logic [1:0]        col;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	// Result element as it leaves the engine.
	typedef struct packed {
		logic              kind;
		logic [1:0]        out_row;
		logic [1:0]        out_col;
		logic [VAL_W-1:0]  out_value;
		logic              error;
		logic              last;
	} res_t;

	function automatic logic signed [ACC_W-1:0] sat_add64(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [ACC_W-1:0] s;
		s = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
			s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > 64'sh7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[VAL_W-1:0];
		return r;
	endfunction

endpackage

[design/kalman_predict_step.sv]
// Top level of the Kalman predict step block.
// The slave stream carries requests: tuser holds the request code (load A, x0,
// y0, x, P, Q, or compute), tdata holds row, column and the signed Q16.16 value.
// Loads write one element and give no result; a load whose row or column lies
// outside DIM is dropped. A compute emits DIM state elements A(x-x0)+y0 and
// then DIM*DIM covariance elements A P A^T + Q on the master stream, with tlast
// on the final one. A compute issued before any A element was loaded gives a
// single result with the error flag set and tlast high.
// Requests pass through a four-entry queue into the compute engine, so the
// sender may run ahead of the engine by four requests. A load leaves the queue
// whenever the engine is idle. A compute runs on one shared multiplier; each
// multiply-accumulate steps through read, multiply and accumulate, each element
// takes a rounding step and each emitted element a handshake step.
// When the receiver stalls, the engine holds its result and waits; the queue
// keeps accepting until it is full.
// Reset clears the queue, the sequencer and the "A loaded" flag; the stored
// matrices and vectors are undefined until loaded.
module kalman_predict_step
	import kps_pkg::*;
#(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // row[1:0], col[3:2], value[35:4], zero fill
	input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // out_row[1:0], out_col[3:2], out_value[35:4]
	output logic [1:0]  m_axis_tuser,  // kind[0], error[1]
	output logic        m_axis_tlast
);

	cmd_t in_cmd, q_cmd;
	res_t res;
	logic q_valid, q_ready;

	assign in_cmd.req   = req_t'(s_axis_tuser);
	assign in_cmd.row   = s_axis_tdata[1:0];
	assign in_cmd.col   = s_axis_tdata[3:2];
	assign in_cmd.value = s_axis_tdata[35:4];

	kps_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	kps_engine #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {4'd0, res.out_value, res.out_col, res.out_row};
	assign m_axis_tuser = {res.error, res.kind};
	assign m_axis_tlast = res.last;

	// An error result is always the only result of its run.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("error result without tlast");

	// Error results carry no covariance kind.
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
		else $error("error result marked as covariance");

	// After a taken result the engine needs cycles before the next one.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
		else $error("back-to-back results from the engine");

endmodule

[design/kps_front.sv]
// Front end: request intake, classification and command queue.
module kps_front
	import kps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic q_valid,
	input  logic q_ready,
	output cmd_t q_cmd
);

	localparam int DEPTH = 4;
	localparam int AW = 2;

	cmd_t            fifo_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;
	logic            push, pop, keep;

	// Requests that do nothing (unused code) are dropped here.
	assign keep     = (in_cmd.req != REQ_NONE);
	assign in_ready = (count_q != (AW+1)'(DEPTH));
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

[design/kps_engine.sv]
// Back end: operand storage, shared multiply-accumulate unit and result sequencer.
module kps_engine
	import kps_pkg::*;
#(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  cmd_t q_cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int EW = (DIM > 1) ? $clog2(DIM*DIM) : 1;
	localparam logic signed [ACC_W-1:0] HALF =
		(FRAC_BITS > 0) ? (ACC_W'(1) <<< (FRAC_BITS-1)) : '0;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_MUL, ST_ACC, ST_FIN, ST_OUT
	} state_t;
	typedef enum logic [1:0] { PH_X, PH_T, PH_C } phase_t;

	logic [VAL_W-1:0] a_mem [DIM*DIM];
	logic [VAL_W-1:0] p_mem [DIM*DIM];
	logic [VAL_W-1:0] q_mem [DIM*DIM];
	logic [VAL_W-1:0] t_mem [DIM*DIM];
	logic [VAL_W-1:0] x0_mem [DIM];
	logic [VAL_W-1:0] y0_mem [DIM];
	logic [VAL_W-1:0] x_mem [DIM];

	state_t  state_q;
	phase_t  phase_q;
	logic    loaded_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic signed [ACC_W-1:0] acc_q, prod_q;
	logic signed [VAL_W-1:0] opa_q, opb_q;
	logic [VAL_W-1:0] addv_q;

	logic in_range, mat;
	logic signed [ACC_W-1:0] rnd, shf;
	logic signed [VAL_W-1:0] rval;
	logic signed [VAL_W-1:0] dval;
	logic last_k, last_j, last_i;

	assign mat = (q_cmd.req == REQ_LOAD_A) || (q_cmd.req == REQ_LOAD_P) ||
	             (q_cmd.req == REQ_LOAD_Q);
	assign in_range = (32'(q_cmd.row) < DIM) && (!mat || (32'(q_cmd.col) < DIM));
	assign q_ready = (state_q == ST_IDLE);

	// Rounding of an accumulated sum back to the element format.
	always_comb begin
		rnd = sat_add64(acc_q, HALF);
		shf = rnd >>> FRAC_BITS;
		rval = sat32(shf);
	end

	assign dval = sat32(ACC_W'($signed(x_mem[k_q])) - ACC_W'($signed(x0_mem[k_q])));
	assign last_k = (32'(k_q) == DIM-1);
	assign last_j = (32'(j_q) == DIM-1);
	assign last_i = (32'(i_q) == DIM-1);

	function automatic logic [EW-1:0] ix(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return EW'(32'(r) * DIM + 32'(c));
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && in_range) begin
			unique case (q_cmd.req)
				REQ_LOAD_A:  a_mem[ix(IW'(q_cmd.row), IW'(q_cmd.col))] <= q_cmd.value;
				REQ_LOAD_P:  p_mem[ix(IW'(q_cmd.row), IW'(q_cmd.col))] <= q_cmd.value;
				REQ_LOAD_Q:  q_mem[ix(IW'(q_cmd.row), IW'(q_cmd.col))] <= q_cmd.value;
				REQ_LOAD_X0: x0_mem[IW'(q_cmd.row)] <= q_cmd.value;
				REQ_LOAD_Y0: y0_mem[IW'(q_cmd.row)] <= q_cmd.value;
				REQ_LOAD_X:  x_mem[IW'(q_cmd.row)] <= q_cmd.value;
				default: ;
			endcase
		end
		if (state_q == ST_FIN && phase_q == PH_T)
			t_mem[ix(i_q, j_q)] <= rval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_X;
			loaded_q  <= 1'b0;
			res_valid <= 1'b0;
			i_q <= '0; j_q <= '0; k_q <= '0;
			acc_q <= '0; prod_q <= '0; opa_q <= '0; opb_q <= '0; addv_q <= '0;
			res <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (q_valid) begin
					if (q_cmd.req == REQ_LOAD_A && in_range)
						loaded_q <= 1'b1;
					if (q_cmd.req == REQ_COMPUTE) begin
						if (!loaded_q) begin
							res <= '{kind: 1'b0, out_row: 2'd0, out_col: 2'd0,
							         out_value: '0, error: 1'b1, last: 1'b1};
							res_valid <= 1'b1;
							state_q <= ST_OUT;
							phase_q <= PH_C;
							i_q <= IW'(DIM-1); j_q <= IW'(DIM-1);
						end else begin
							phase_q <= PH_X;
							i_q <= '0; j_q <= '0; k_q <= '0;
							acc_q <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					unique case (phase_q)
						PH_X: begin opa_q <= a_mem[ix(i_q, k_q)]; opb_q <= dval; end
						PH_T: begin opa_q <= a_mem[ix(i_q, k_q)]; opb_q <= p_mem[ix(k_q, j_q)]; end
						default: begin opa_q <= t_mem[ix(i_q, k_q)]; opb_q <= a_mem[ix(j_q, k_q)]; end
					endcase
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= ACC_W'(opa_q) * ACC_W'(opb_q);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= sat_add64(acc_q, prod_q);
					if (last_k) begin
						k_q <= '0;
						addv_q <= (phase_q == PH_X) ? y0_mem[i_q] : q_mem[ix(i_q, j_q)];
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					acc_q <= '0;
					if (phase_q == PH_T) begin
						if (last_j) begin
							j_q <= '0;
							if (last_i) begin i_q <= '0; phase_q <= PH_C; end
							else i_q <= i_q + 1'b1;
						end else j_q <= j_q + 1'b1;
						state_q <= ST_RD;
					end else begin
						res <= '{kind: (phase_q == PH_C), out_row: 2'(i_q),
						         out_col: (phase_q == PH_C) ? 2'(j_q) : 2'd0,
						         out_value: sat32(ACC_W'(rval) + ACC_W'($signed(addv_q))),
						         error: 1'b0,
						         last: (phase_q == PH_C) && last_i && last_j};
						res_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (res_ready) begin
					res_valid <= 1'b0;
					state_q <= ST_RD;
					if (phase_q == PH_X) begin
						if (last_i) begin i_q <= '0; phase_q <= PH_T; end
						else i_q <= i_q + 1'b1;
					end else begin
						if (last_j) begin
							j_q <= '0;
							if (last_i) begin i_q <= '0; state_q <= ST_IDLE; end
							else i_q <= i_q + 1'b1;
						end else j_q <= j_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[verif/tb_kalman_predict_step.sv]
// Self-checking testbench for the Kalman predict step block.
module tb_kalman_predict_step;
	import kps_pkg::*;

	localparam int DIM = 4;
	localparam int FRAC_BITS = 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 700;

	typedef struct {
		bit        kind;
		bit [1:0]  row;
		bit [1:0]  col;
		int        value;
		bit        err;
		bit        last;
	} elem_t;

	// Tracks the loaded matrices and holds the elements each compute should emit.
	class predict_scoreboard;
		int    a_mat[DIM*DIM];
		int    x0_vec[DIM];
		int    y0_vec[DIM];
		int    x_vec[DIM];
		int    p_mat[DIM*DIM];
		int    q_mat[DIM*DIM];
		bit    a_seen;
		elem_t pending_q[$];
		int    errors;

		function longint add_sat64(longint a, longint b);
			longint s;
			s = a + b;
			if (a[63] == b[63] && s[63] != a[63])
				s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
			return s;
		endfunction

		function int clip32(longint v);
			if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
			if (v < -64'sd2147483648) return 32'sh8000_0000;
			return int'(v);
		endfunction

		function int round_q(longint acc);
			if (FRAC_BITS > 0)
				acc = add_sat64(acc, 64'sd1 <<< (FRAC_BITS - 1));
			return clip32(acc >>> FRAC_BITS);
		endfunction

		function void push(bit kind, int r, int c, int v, bit err, bit last);
			elem_t e;
			e.kind = kind; e.row = 2'(r); e.col = 2'(c); e.value = v; e.err = err;
			e.last = last;
			pending_q.push_back(e);
		endfunction

		// Called for every accepted request.
		function void note_request(req_t req, int r, int c, int v);
			int     tmp[DIM*DIM];
			longint acc;
			int     d;
			case (req)
				REQ_LOAD_A: begin a_mat[r*DIM+c] = v; a_seen = 1; end
				REQ_LOAD_X0: x0_vec[r] = v;
				REQ_LOAD_Y0: y0_vec[r] = v;
				REQ_LOAD_X: x_vec[r] = v;
				REQ_LOAD_P: p_mat[r*DIM+c] = v;
				REQ_LOAD_Q: q_mat[r*DIM+c] = v;
				REQ_COMPUTE: begin
					if (!a_seen) begin
						push(1'b0, 0, 0, 0, 1'b1, 1'b1);
						return;
					end
					for (int i = 0; i < DIM; i++) begin
						acc = 0;
						for (int k = 0; k < DIM; k++) begin
							d = clip32(longint'(x_vec[k]) - longint'(x0_vec[k]));
							acc = add_sat64(acc, longint'(a_mat[i*DIM+k]) * longint'(d));
						end
						push(1'b0, i, 0, clip32(longint'(round_q(acc)) + longint'(y0_vec[i])),
							1'b0, 1'b0);
					end
					for (int i = 0; i < DIM; i++)
						for (int j = 0; j < DIM; j++) begin
							acc = 0;
							for (int k = 0; k < DIM; k++)
								acc = add_sat64(acc,
									longint'(a_mat[i*DIM+k]) * longint'(p_mat[k*DIM+j]));
							tmp[i*DIM+j] = round_q(acc);
						end
					for (int i = 0; i < DIM; i++)
						for (int j = 0; j < DIM; j++) begin
							acc = 0;
							for (int k = 0; k < DIM; k++)
								acc = add_sat64(acc,
									longint'(tmp[i*DIM+k]) * longint'(a_mat[j*DIM+k]));
							push(1'b1, i, j,
								clip32(longint'(round_q(acc)) + longint'(q_mat[i*DIM+j])),
								1'b0, (i == DIM-1) && (j == DIM-1));
						end
				end
				default: ;
			endcase
		endfunction

		// Called for every accepted result element.
		function void check_result(elem_t got);
			elem_t want;
			if (pending_q.size() == 0) begin
				$error("unexpected result: row %0d col %0d value %0d",
					got.row, got.col, got.value);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.kind != want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
			end
			if (got.row != want.row) begin
				$error("out_row: expected %0d, got %0d", want.row, got.row); errors++;
			end
			if (got.col != want.col) begin
				$error("out_col: expected %0d, got %0d", want.col, got.col); errors++;
			end
			if (got.value != want.value) begin
				$error("out_value: expected %0d, got %0d", want.value, got.value); errors++;
			end
			if (got.err != want.err) begin
				$error("error: expected %0d, got %0d", want.err, got.err); errors++;
			end
			if (got.last != want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	predict_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int quiet_cycles;

	kalman_predict_step #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready = 1'b0;
				hold_cycles--;
			end else
				m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Result monitor and watchdog.
	always @(posedge clk) begin
		elem_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser[0];
				got.err = m_axis_tuser[1];
				got.row = m_axis_tdata[1:0];
				got.col = m_axis_tdata[3:2];
				got.value = m_axis_tdata[35:4];
				got.last = m_axis_tlast;
				sb.check_result(got);
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Issues one request; entered and left at a falling edge.
	task automatic send_request(req_t req, int r, int c, int v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = req;
		s_axis_tdata = {4'b0, v[31:0], c[1:0], r[1:0]};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(req, r, c, v);
		@(negedge clk);
	endtask

	task automatic load_all(int a_diag, int x0_val, int y0_val);
		for (int i = 0; i < DIM; i++) begin
			send_request(REQ_LOAD_X0, i, 0, x0_val);
			send_request(REQ_LOAD_Y0, i, 0, y0_val);
			send_request(REQ_LOAD_X, i, $urandom_range(3), $urandom());
			for (int j = 0; j < DIM; j++) begin
				send_request(REQ_LOAD_A, i, j, (i == j) ? a_diag : $urandom_range(8191));
				send_request(REQ_LOAD_P, i, j, $urandom_range(131071) - 65536);
				send_request(REQ_LOAD_Q, i, j, $urandom());
			end
		end
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic int pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) return int'($urandom_range(524287)) - 262144;
		if (sel < 85) return $urandom();
		case ($urandom_range(4))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 0;
			3: return 1;
			default: return -1;
		endcase
	endfunction

	initial begin
		req_t req;
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_NONE;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Compute with no transition matrix yet gives the error result;
		// the unused code is dropped.
		send_request(REQ_COMPUTE, 0, 0, 0);
		send_request(REQ_NONE, 3, 3, -1);
		drain();

		// Linear set-up: offsets at zero, unit diagonal.
		load_all(32'sh0001_0000, 0, 0);
		send_request(REQ_COMPUTE, 3, 3, 0);
		// Extreme values to push every stage into saturation.
		for (int i = 0; i < DIM; i++) begin
			send_request(REQ_LOAD_A, i, i, (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
			send_request(REQ_LOAD_X, i, 0, (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
			send_request(REQ_LOAD_X0, i, 0, (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
			send_request(REQ_LOAD_P, i, i, 32'sh7FFF_FFFF);
		end
		send_request(REQ_COMPUTE, 0, 0, 0);
		drain();

		// Random phases, one per idling mix.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			// The long hold-off lets the request queue fill behind a compute.
			if (phase == 2) begin
				send_request(REQ_COMPUTE, 0, 0, 0);
				hold_cycles = 1500;
				for (int n = 0; n < 8; n++)
					send_request(REQ_LOAD_Q, n % DIM, (n + 1) % DIM, pick_value());
				send_request(REQ_COMPUTE, 1, 2, 0);
			end
			for (int n = 0; n < 20; n++) begin
				case ($urandom_range(15))
					0, 1: req = REQ_COMPUTE;
					2: req = REQ_NONE;
					default: req = req_t'($urandom_range(5));
				endcase
				send_request(req, $urandom_range(3), $urandom_range(3), pick_value());
			end
			drain();
		end

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
